// ===== rtl/pqs_pkg.sv =====
// Shared types and constants for the priority queue selector.
// No dependencies; used by pqs_ctrl, pqs_dp and priority_queue_selector.
package pqs_pkg;

    // Fixed field widths
    localparam int QIDX_W    = 3;
    localparam int STAMP_W   = 32;
    localparam int TYPE_W    = 2;
    localparam int MAP_W     = 16;
    localparam int FIELD_W   = 2;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIO_MAP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TYPE_MAP = 2'd2;

    // Selection modes
    localparam logic MODE_PRIO = 1'b0;
    localparam logic MODE_RR   = 1'b1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;    // transfer one status item into the round state
        logic decide;  // pick the winner, register the result, clear the round
    } t_cmd;

endpackage

// ===== rtl/pqs_ctrl.sv =====
// Controller state machine for the priority queue selector.
// Depends on pqs_pkg; drives load and decide commands to pqs_dp.
module pqs_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_final_item,
    output logic          o_busy,
    output pqs_pkg::t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_DECIDE = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state: a final item leads to S_DECIDE for the decision
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start && i_final_item) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Issue commands
    assign o_busy       = (r_state == S_DECIDE);
    assign o_cmd.load   = i_start && (r_state == S_IDLE);
    assign o_cmd.decide = (r_state == S_DECIDE);

endmodule

// ===== rtl/pqs_dp.sv =====
// Datapath of the priority queue selector: configuration registers,
// per-level and per-type round state, decision logic and result register.
// Depends on pqs_pkg; controlled by pqs_ctrl through pqs_pkg::t_cmd.
module pqs_dp #(
    parameter int QUEUES      = 8,
    parameter int PRIO_LEVELS = 4,
    parameter int JOB_TYPES   = 4,
    parameter int STAMP_BITS  = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  pqs_pkg::t_cmd                  i_cmd,
    input  logic                           i_cfg_wr,
    input  logic [pqs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pqs_pkg::MAP_W-1:0]      i_cfg_data,
    input  logic [pqs_pkg::QIDX_W-1:0]     i_queue_index,
    input  logic                           i_occupied,
    input  logic [pqs_pkg::STAMP_W-1:0]    i_head_stamp,
    input  logic [pqs_pkg::TYPE_W-1:0]     i_last_type,
    output logic                           o_done,
    output logic                           o_found,
    output logic [pqs_pkg::QIDX_W-1:0]     o_chosen_queue
);

    localparam int SW = (STAMP_BITS < pqs_pkg::STAMP_W) ? STAMP_BITS : pqs_pkg::STAMP_W;
    localparam logic [5:0] QN = 6'(QUEUES);

    // Configuration
    logic                      r_mode;
    logic [pqs_pkg::MAP_W-1:0] r_prio_map;
    logic [pqs_pkg::MAP_W-1:0] r_type_map;

    // Round state
    logic [SW-1:0]                 r_lv_stamp [PRIO_LEVELS];
    logic [pqs_pkg::QIDX_W-1:0]    r_lv_index [PRIO_LEVELS];
    logic [PRIO_LEVELS-1:0]        r_lv_seen;
    logic [pqs_pkg::QIDX_W-1:0]    r_ty_index [JOB_TYPES];
    logic [JOB_TYPES-1:0]          r_ty_seen;
    logic [pqs_pkg::TYPE_W-1:0]    r_last_type;

    // Result
    logic                          r_done;
    logic                          r_found;
    logic [pqs_pkg::QIDX_W-1:0]    r_chosen;

    logic                           q_ok;
    logic [pqs_pkg::FIELD_W-1:0]    lv;
    logic [pqs_pkg::FIELD_W-1:0]    ty;
    logic [SW-1:0]                  stamp;
    logic [PRIO_LEVELS-1:0]         lv_upd;
    logic [JOB_TYPES-1:0]           ty_upd;
    logic                           n_found;
    logic [pqs_pkg::QIDX_W-1:0]     n_chosen;
    logic                           lv_hit;
    logic [pqs_pkg::QIDX_W-1:0]     lv_pick;
    logic                           ty_hit;
    logic [pqs_pkg::QIDX_W-1:0]     ty_pick;
    logic [3:0]                     rr_start;
    logic [3:0]                     rr_t;

    // Look up level and type of the incoming queue
    assign q_ok  = i_occupied && ({3'b000, i_queue_index} < QN);
    assign lv    = r_prio_map[{i_queue_index, 1'b0} +: pqs_pkg::FIELD_W];
    assign ty    = r_type_map[{i_queue_index, 1'b0} +: pqs_pkg::FIELD_W];
    assign stamp = i_head_stamp[SW-1:0];

    // Decide which level entries take the item: oldest stamp, lower index on ties
    always_comb begin
        for (int k = 0; k < PRIO_LEVELS; k++) begin
            lv_upd[k] = i_cmd.load && q_ok && ({2'b00, lv} == 4'(k)) &&
                        (!r_lv_seen[k] || (stamp < r_lv_stamp[k]) ||
                         ((stamp == r_lv_stamp[k]) && (i_queue_index < r_lv_index[k])));
        end
    end

    // Decide which type entries take the item: lowest index
    always_comb begin
        for (int k = 0; k < JOB_TYPES; k++) begin
            ty_upd[k] = i_cmd.load && q_ok && ({2'b00, ty} == 4'(k)) &&
                        (!r_ty_seen[k] || (i_queue_index < r_ty_index[k]));
        end
    end

    // Pick the most urgent level that holds a candidate
    always_comb begin
        lv_hit  = 1'b0;
        lv_pick = '0;
        for (int k = PRIO_LEVELS - 1; k >= 0; k--) begin
            if (r_lv_seen[k]) begin
                lv_hit  = 1'b1;
                lv_pick = r_lv_index[k];
            end
        end
    end

    // Rotate through job types starting after the last scheduled one
    always_comb begin
        rr_start = {2'b00, r_last_type} + 4'd1;
        for (int s = 0; s < 4; s++) begin
            if (rr_start >= 4'(JOB_TYPES)) begin
                rr_start = rr_start - 4'(JOB_TYPES);
            end
        end
        ty_hit  = 1'b0;
        ty_pick = '0;
        rr_t    = rr_start;
        for (int j = 0; j < JOB_TYPES; j++) begin
            for (int k = 0; k < JOB_TYPES; k++) begin
                if (!ty_hit && (rr_t == 4'(k)) && r_ty_seen[k]) begin
                    ty_hit  = 1'b1;
                    ty_pick = r_ty_index[k];
                end
            end
            rr_t = (rr_t + 4'd1 == 4'(JOB_TYPES)) ? 4'd0 : rr_t + 4'd1;
        end
    end

    // Select by mode
    always_comb begin
        case (r_mode)
            pqs_pkg::MODE_RR: begin
                n_found  = ty_hit;
                n_chosen = ty_pick;
            end
            default: begin
                n_found  = lv_hit;
                n_chosen = lv_pick;
            end
        endcase
    end

    // Write configuration registers; drop writes beyond the register list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= 1'b0;
            r_prio_map <= '0;
            r_type_map <= '0;
        end else if (i_cfg_wr) begin
            unique case (i_cfg_index)
                pqs_pkg::CFG_MODE:     r_mode     <= i_cfg_data[0];
                pqs_pkg::CFG_PRIO_MAP: r_prio_map <= i_cfg_data;
                pqs_pkg::CFG_TYPE_MAP: r_type_map <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Track seen flags; clear them when the round is decided
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lv_seen <= '0;
            r_ty_seen <= '0;
        end else if (i_cmd.decide) begin
            r_lv_seen <= '0;
            r_ty_seen <= '0;
        end else begin
            r_lv_seen <= r_lv_seen | lv_upd;
            r_ty_seen <= r_ty_seen | ty_upd;
        end
    end

    // Hold best stamp and index per level and per type
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < PRIO_LEVELS; k++) begin
            if (lv_upd[k]) begin
                r_lv_stamp[k] <= stamp;
                r_lv_index[k] <= i_queue_index;
            end
        end
        for (int k = 0; k < JOB_TYPES; k++) begin
            if (ty_upd[k]) begin
                r_ty_index[k] <= i_queue_index;
            end
        end
        if (i_cmd.load) begin
            r_last_type <= i_last_type;
        end
    end

    // Register the result; the strobe lasts one cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.decide;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.decide) begin
            r_found  <= n_found;
            r_chosen <= n_found ? n_chosen : '0;
        end
    end

    assign o_done         = r_done;
    assign o_found        = r_found;
    assign o_chosen_queue = r_chosen;

endmodule

// ===== rtl/priority_queue_selector.sv =====
// Top level of the priority queue selector: controller plus datapath.
// Depends on pqs_pkg, pqs_ctrl and pqs_dp.
//
// Queue status items are taken when i_start is high and o_busy is low, one
// per cycle. Each item is folded into the round state on the cycle it is
// accepted: a two-bit map lookup and one timestamp compare per level. An
// item with i_final_item set is followed by a decision step (o_busy high)
// that runs the level or job-type selection and clears the round state. The
// result shows on o_found and o_chosen_queue for exactly one cycle with
// o_done high, the cycle after the decision; the receiver cannot stall it,
// and a new item may be accepted in that same cycle. Configuration writes
// are always ready and should be made only while no round is in progress.
module priority_queue_selector #(
    parameter int QUEUES      = 8,
    parameter int PRIO_LEVELS = 4,
    parameter int JOB_TYPES   = 4,
    parameter int STAMP_BITS  = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    output logic                           o_busy,
    input  logic [pqs_pkg::QIDX_W-1:0]     i_queue_index,
    input  logic                           i_occupied,
    input  logic [pqs_pkg::STAMP_W-1:0]    i_head_stamp,
    input  logic [pqs_pkg::TYPE_W-1:0]     i_last_type,
    input  logic                           i_final_item,
    output logic                           o_done,
    output logic                           o_found,
    output logic [pqs_pkg::QIDX_W-1:0]     o_chosen_queue,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [pqs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pqs_pkg::MAP_W-1:0]      i_cfg_data
);

    pqs_pkg::t_cmd cmd;

    assign o_cfg_ready = 1'b1;

    pqs_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .i_final_item (i_final_item),
        .o_busy       (o_busy),
        .o_cmd        (cmd)
    );

    pqs_dp #(
        .QUEUES      (QUEUES),
        .PRIO_LEVELS (PRIO_LEVELS),
        .JOB_TYPES   (JOB_TYPES),
        .STAMP_BITS  (STAMP_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_cfg_wr       (i_cfg_valid && o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_queue_index  (i_queue_index),
        .i_occupied     (i_occupied),
        .i_head_stamp   (i_head_stamp),
        .i_last_type    (i_last_type),
        .o_done         (o_done),
        .o_found        (o_found),
        .o_chosen_queue (o_chosen_queue)
    );

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for priority_queue_selector: directed table, then random rounds.
// Depends on pqs_pkg and the priority_queue_selector RTL; carries its own arbitration predictor.
module tb_top;

    localparam int NUM_QUEUES   = 8;
    localparam int NUM_LEVELS   = 4;
    localparam int NUM_TYPES    = 4;
    localparam int RANDOM_ITEMS = 1350;
    localparam int SETTLE_CYC   = 4;
    localparam int DRAIN_CYC    = 10;
    localparam int CYCLE_LIMIT  = 400000;

    // Register index the block does not decode; writes to it must be ignored
    localparam logic [pqs_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic                         found;
        logic [pqs_pkg::QIDX_W-1:0]   queue;
    } t_pick;

    typedef enum bit {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind                       kind;
        logic [pqs_pkg::QIDX_W-1:0]      qidx;
        logic                            occ;
        logic [pqs_pkg::STAMP_W-1:0]     stamp;
        logic [pqs_pkg::TYPE_W-1:0]      last;
        logic                            fin;
        bit                              known;
        t_pick                           known_pick;
        logic [pqs_pkg::CFG_IDX_W-1:0]   reg_idx;
        logic [pqs_pkg::MAP_W-1:0]       reg_data;
    } t_row;

    typedef struct {
        logic [pqs_pkg::QIDX_W-1:0]   qidx;
        logic                         occ;
        logic [pqs_pkg::STAMP_W-1:0]  stamp;
    } t_status;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_start = 1'b0;
    logic                            o_busy;
    logic [pqs_pkg::QIDX_W-1:0]      i_queue_index = '0;
    logic                            i_occupied = 1'b0;
    logic [pqs_pkg::STAMP_W-1:0]     i_head_stamp = '0;
    logic [pqs_pkg::TYPE_W-1:0]      i_last_type = '0;
    logic                            i_final_item = 1'b0;
    logic                            o_done;
    logic                            o_found;
    logic [pqs_pkg::QIDX_W-1:0]      o_chosen_queue;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [pqs_pkg::CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [pqs_pkg::MAP_W-1:0]       i_cfg_data = '0;

    // Tags driven alongside each item: a hand-written expectation for the table rows
    bit                              row_known = 1'b0;
    t_pick                           row_pick = '0;

    // Predictor copy of the registers and the per-round state
    logic                            arb_mode;
    logic [pqs_pkg::MAP_W-1:0]       arb_prio_map;
    logic [pqs_pkg::MAP_W-1:0]       arb_type_map;
    logic [pqs_pkg::STAMP_W-1:0]     lvl_stamp [NUM_LEVELS];
    logic [pqs_pkg::QIDX_W-1:0]      lvl_queue [NUM_LEVELS];
    bit                              lvl_hit   [NUM_LEVELS];
    logic [pqs_pkg::QIDX_W-1:0]      typ_queue [NUM_TYPES];
    bit                              typ_hit   [NUM_TYPES];

    t_pick                           pending_picks [$];
    t_row                            dir_rows [$];

    int                              errors = 0;
    int                              items_sent = 0;
    int                              picks_checked = 0;
    int                              rr_picks = 0;
    int                              reg_writes = 0;
    int                              cycles = 0;

    priority_queue_selector i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_queue_index  (i_queue_index),
        .i_occupied     (i_occupied),
        .i_head_stamp   (i_head_stamp),
        .i_last_type    (i_last_type),
        .i_final_item   (i_final_item),
        .o_done         (o_done),
        .o_found        (o_found),
        .o_chosen_queue (o_chosen_queue),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Drop all per-round candidates
    function automatic void clear_round();
        int k;
        for (k = 0; k < NUM_LEVELS; k++) begin
            lvl_stamp[k] = '0;
            lvl_queue[k] = '0;
            lvl_hit[k]   = 1'b0;
        end
        for (k = 0; k < NUM_TYPES; k++) begin
            typ_queue[k] = '0;
            typ_hit[k]   = 1'b0;
        end
    endfunction

    // Fold one queue status into the round; on the final item pick the winner
    function automatic bit arbitrate(input logic [pqs_pkg::QIDX_W-1:0] qidx, input logic occ,
                                     input logic [pqs_pkg::STAMP_W-1:0] stamp,
                                     input logic [pqs_pkg::TYPE_W-1:0] last,
                                     input logic fin, output t_pick pick);
        int lv;
        int ty;
        int t;
        int k;
        pick = '0;
        if (occ && qidx < NUM_QUEUES) begin
            lv = int'(arb_prio_map[2*qidx +: 2]);
            ty = int'(arb_type_map[2*qidx +: 2]);
            if (lv < NUM_LEVELS) begin
                if (!lvl_hit[lv] || stamp < lvl_stamp[lv] ||
                    (stamp == lvl_stamp[lv] && qidx < lvl_queue[lv])) begin
                    lvl_hit[lv]   = 1'b1;
                    lvl_stamp[lv] = stamp;
                    lvl_queue[lv] = qidx;
                end
            end
            if (ty < NUM_TYPES) begin
                if (!typ_hit[ty] || qidx < typ_queue[ty]) begin
                    typ_hit[ty]   = 1'b1;
                    typ_queue[ty] = qidx;
                end
            end
        end
        if (!fin)
            return 1'b0;
        if (arb_mode == pqs_pkg::MODE_PRIO) begin
            for (k = 0; k < NUM_LEVELS; k++) begin
                if (!pick.found && lvl_hit[k])
                    pick = '{found: 1'b1, queue: lvl_queue[k]};
            end
        end else begin
            // Rotation starts at the type after the last scheduled one
            t = (int'(last) + 1) % NUM_TYPES;
            for (k = 0; k < NUM_TYPES; k++) begin
                if (!pick.found && typ_hit[t])
                    pick = '{found: 1'b1, queue: typ_queue[t]};
                t = (t + 1) % NUM_TYPES;
            end
        end
        clear_round();
        return 1'b1;
    endfunction

    // Track register writes, compare picks, queue expectations for accepted items
    always @(posedge i_clk) begin
        t_pick pick;
        t_pick want;
        if (!i_rst_n) begin
            arb_mode     = pqs_pkg::MODE_PRIO;
            arb_prio_map = '0;
            arb_type_map = '0;
            clear_round();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                reg_writes++;
                case (i_cfg_index)
                    pqs_pkg::CFG_MODE:     arb_mode = i_cfg_data[0];
                    pqs_pkg::CFG_PRIO_MAP: arb_prio_map = i_cfg_data;
                    pqs_pkg::CFG_TYPE_MAP: arb_type_map = i_cfg_data;
                    default: ;
                endcase
            end
            if (o_done) begin
                if (pending_picks.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected pick found=%0b queue=%0d", $time,
                             o_found, o_chosen_queue);
                end else begin
                    want = pending_picks.pop_front();
                    picks_checked++;
                    if (o_found !== want.found) begin
                        errors++;
                        $display("%0t: found mismatch, expected %0b, got %0b", $time,
                                 want.found, o_found);
                    end
                    if (o_chosen_queue !== want.queue) begin
                        errors++;
                        $display("%0t: chosen_queue mismatch, expected %0d, got %0d",
                                 $time, want.queue, o_chosen_queue);
                    end
                end
            end
            if (i_start && !o_busy) begin
                if (arbitrate(i_queue_index, i_occupied, i_head_stamp, i_last_type,
                              i_final_item, pick)) begin
                    if (arb_mode == pqs_pkg::MODE_RR)
                        rr_picks++;
                    pending_picks.push_back(row_known ? row_pick : pick);
                end
            end
        end
    end

    // Run watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d picks outstanding", cycles,
                     pending_picks.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic hold_off(input int n);
        if (n > 0) begin
            i_start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Present one status item and hold it until the transfer
    task automatic send_status(input logic [pqs_pkg::QIDX_W-1:0] qidx, input logic occ,
                               input logic [pqs_pkg::STAMP_W-1:0] stamp,
                               input logic [pqs_pkg::TYPE_W-1:0] last, input logic fin,
                               input bit known, input t_pick known_pick);
        i_start       <= 1'b1;
        i_queue_index <= qidx;
        i_occupied    <= occ;
        i_head_stamp  <= stamp;
        i_last_type   <= last;
        i_final_item  <= fin;
        row_known     <= known;
        row_pick      <= known_pick;
        do @(posedge i_clk); while (o_busy);
        items_sent++;
    endtask

    // Wait for every pick to arrive, then let the decision pipeline drain
    task automatic settle();
        i_start <= 1'b0;
        while (pending_picks.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // Make exactly one register transfer, then drop valid
    task automatic write_reg(input logic [pqs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [pqs_pkg::MAP_W-1:0] data);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [pqs_pkg::MAP_W-1:0] draw_map();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return '1;
            default: return pqs_pkg::MAP_W'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic add_item(input logic [pqs_pkg::QIDX_W-1:0] qidx, input logic occ,
                            input logic [pqs_pkg::STAMP_W-1:0] stamp,
                            input logic [pqs_pkg::TYPE_W-1:0] last,
                            input logic fin, input bit known, input logic found,
                            input logic [pqs_pkg::QIDX_W-1:0] queue);
        t_row r;
        r.kind       = ROW_ITEM;
        r.qidx       = qidx;
        r.occ        = occ;
        r.stamp      = stamp;
        r.last       = last;
        r.fin        = fin;
        r.known      = known;
        r.known_pick = '{found: found, queue: queue};
        r.reg_idx    = '0;
        r.reg_data   = '0;
        dir_rows.push_back(r);
    endtask

    task automatic add_reg(input logic [pqs_pkg::CFG_IDX_W-1:0] idx,
                           input logic [pqs_pkg::MAP_W-1:0] data);
        t_row r;
        r.kind       = ROW_CFG;
        r.qidx       = '0;
        r.occ        = 1'b0;
        r.stamp      = '0;
        r.last       = '0;
        r.fin        = 1'b0;
        r.known      = 1'b0;
        r.known_pick = '0;
        r.reg_idx    = idx;
        r.reg_data   = data;
        dir_rows.push_back(r);
    endtask

    // One round of queue status items ending in a final item
    task automatic run_round(inout int sent);
        t_status items [$];
        t_status s;
        int density;
        int stamp_kind;
        int n;
        int q;
        int i;
        bit no_gap;
        density    = ($urandom_range(0, 2) == 0) ? 15 : (($urandom_range(0, 1) != 0) ? 60 : 95);
        stamp_kind = $urandom_range(0, 3);
        no_gap     = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 9) < 8) begin
            // Well-formed: a rising subset of the queues
            for (q = 0; q < NUM_QUEUES; q++) begin
                if ($urandom_range(0, 3) != 0) begin
                    s.qidx = pqs_pkg::QIDX_W'(q);
                    items.push_back(s);
                end
            end
            if (items.size() == 0) begin
                s.qidx = pqs_pkg::QIDX_W'($urandom_range(0, NUM_QUEUES - 1));
                items.push_back(s);
            end
        end else begin
            // Noise: any order, repeats allowed
            n = $urandom_range(1, 10);
            repeat (n) begin
                s.qidx = pqs_pkg::QIDX_W'($urandom_range(0, NUM_QUEUES - 1));
                items.push_back(s);
            end
        end
        for (i = 0; i < items.size(); i++) begin
            items[i].occ = ($urandom_range(0, 99) < density);
            case (stamp_kind)
                0: items[i].stamp = $urandom_range(0, 3);
                1: begin
                    case ($urandom_range(0, 3))
                        0: items[i].stamp = '0;
                        1: items[i].stamp = '1;
                        2: items[i].stamp = 32'h7FFF_FFFF;
                        default: items[i].stamp = 32'h8000_0000;
                    endcase
                end
                default: items[i].stamp = $urandom;
            endcase
        end
        for (i = 0; i < items.size(); i++) begin
            if (!no_gap)
                hold_off(pick_gap());
            send_status(items[i].qidx, items[i].occ, items[i].stamp,
                        pqs_pkg::TYPE_W'($urandom_range(0, 3)), i == items.size() - 1,
                        1'b0, '0);
            sent++;
        end
    endtask

    initial begin
        int random_sent;
        int dir_items;
        random_sent = 0;

        // Directed table; after reset every queue is level 0 and type 0
        add_item(3'd0, 1'b0, 32'h0,         2'd0, 1'b1, 1'b1, 1'b0, 3'd0);
        add_item(3'd7, 1'b1, 32'hFFFF_FFFF, 2'd0, 1'b0, 1'b0, 1'b0, 3'd0);
        add_item(3'd3, 1'b1, 32'hFFFF_FFFF, 2'd0, 1'b0, 1'b0, 1'b0, 3'd0);
        add_item(3'd5, 1'b1, 32'h0,         2'd3, 1'b1, 1'b1, 1'b1, 3'd5);
        add_item(3'd6, 1'b1, 32'd100,       2'd0, 1'b0, 1'b0, 1'b0, 3'd0);
        add_item(3'd2, 1'b1, 32'd100,       2'd0, 1'b1, 1'b1, 1'b1, 3'd2);
        add_reg(pqs_pkg::CFG_PRIO_MAP, 16'hFFFF);
        add_reg(pqs_pkg::CFG_TYPE_MAP, 16'hFFFF);
        // An empty final item only closes the round
        add_item(3'd4, 1'b1, 32'd5,         2'd0, 1'b0, 1'b0, 1'b0, 3'd0);
        add_item(3'd1, 1'b0, 32'h0,         2'd0, 1'b1, 1'b1, 1'b1, 3'd4);
        // Only queue 7 at the top level: the level beats the older stamp
        add_reg(pqs_pkg::CFG_PRIO_MAP, 16'h3FFF);
        add_item(3'd0, 1'b1, 32'h0,         2'd0, 1'b0, 1'b0, 1'b0, 3'd0);
        add_item(3'd7, 1'b1, 32'hFFFF_FFFF, 2'd0, 1'b1, 1'b1, 1'b1, 3'd7);
        // Round robin with types 3,2,1,0 repeating over the queues
        add_reg(pqs_pkg::CFG_TYPE_MAP, 16'h1B1B);
        add_reg(pqs_pkg::CFG_MODE, 16'h0001);
        add_item(3'd2, 1'b1, 32'd9,         2'd0, 1'b0, 1'b0, 1'b0, 3'd0);
        add_item(3'd7, 1'b1, 32'd9,         2'd3, 1'b1, 1'b0, 1'b0, 3'd0);
        add_item(3'd6, 1'b1, 32'd1,         2'd0, 1'b1, 1'b0, 1'b0, 3'd0);
        add_item(3'd1, 1'b0, 32'd1,         2'd2, 1'b1, 1'b1, 1'b0, 3'd0);
        // Out of order and repeated items
        add_item(3'd5, 1'b1, 32'd3,         2'd0, 1'b0, 1'b0, 1'b0, 3'd0);
        add_item(3'd1, 1'b1, 32'd3,         2'd0, 1'b0, 1'b0, 1'b0, 3'd0);
        add_item(3'd5, 1'b1, 32'd3,         2'd2, 1'b1, 1'b0, 1'b0, 3'd0);
        // Only bit 0 of the mode counts; the spare index is ignored
        add_reg(pqs_pkg::CFG_MODE, 16'hFFFE);
        add_reg(CFG_SPARE, 16'hFFFF);
        add_item(3'd3, 1'b1, 32'd1,         2'd1, 1'b1, 1'b1, 1'b1, 3'd3);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_data);
            end else begin
                hold_off(pick_gap());
                send_status(dir_rows[i].qidx, dir_rows[i].occ, dir_rows[i].stamp,
                            dir_rows[i].last, dir_rows[i].fin, dir_rows[i].known,
                            dir_rows[i].known_pick);
            end
        end
        dir_items = items_sent;

        // Random rounds, reprogramming the mode and maps now and then
        while (random_sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 7) == 0) begin
                write_reg(pqs_pkg::CFG_MODE, pqs_pkg::MAP_W'($urandom_range(0, 65535)));
                write_reg(pqs_pkg::CFG_PRIO_MAP, draw_map());
                write_reg(pqs_pkg::CFG_TYPE_MAP, draw_map());
                if ($urandom_range(0, 3) == 0)
                    write_reg(CFG_SPARE, draw_map());
            end
            run_round(random_sent);
        end

        settle();
        repeat (DRAIN_CYC) @(posedge i_clk);

        $display("sent %0d status items (%0d from the table), checked %0d picks", items_sent,
                 dir_items, picks_checked);
        $display("%0d picks in round-robin mode, %0d register writes", rr_picks, reg_writes);
        if (errors == 0 && pending_picks.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d errors, %0d picks never seen", errors, pending_picks.size());
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
